[design/rv32ie_pkg.sv]
// Shared types and constants for the RV32I instruction executor.
// No dependencies; every other design file imports this package.
package rv32ie_pkg;

    localparam int MEM_BYTES = 4096;
    localparam int MEM_ROWS  = MEM_BYTES / 4;
    localparam int ROW_W     = $clog2(MEM_ROWS);

    localparam logic [6:0] OP_LUI    = 7'h37;
    localparam logic [6:0] OP_AUIPC  = 7'h17;
    localparam logic [6:0] OP_JAL    = 7'h6f;
    localparam logic [6:0] OP_JALR   = 7'h67;
    localparam logic [6:0] OP_BRANCH = 7'h63;
    localparam logic [6:0] OP_LOAD   = 7'h03;
    localparam logic [6:0] OP_STORE  = 7'h23;
    localparam logic [6:0] OP_IMM    = 7'h13;
    localparam logic [6:0] OP_REG    = 7'h33;
    localparam logic [6:0] OP_FENCE  = 7'h0f;
    localparam logic [6:0] OP_SYSTEM = 7'h73;

    localparam logic [31:0] UPPER_MASK = 32'hfffff000;

    localparam logic [2:0] F3_BYTE  = 3'd0;
    localparam logic [2:0] F3_HALF  = 3'd1;
    localparam logic [2:0] F3_WORD  = 3'd2;
    localparam logic [2:0] F3_BYTEU = 3'd4;
    localparam logic [2:0] F3_HALFU = 3'd5;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_LOAD
    } state_t;

    typedef struct packed {
        logic [31:0] next_pc;
        logic        wr;
        logic [31:0] val;
        logic        mw;
        logic [31:0] addr;
        logic        unk;
        logic        is_load;
    } exec_res_t;

endpackage

[design/rv32i_instruction_executor.sv]
// RV32I instruction executor: top level with sequencing, pc and result register.
// Instantiates rv32ie_regfile, rv32ie_dmem and rv32ie_exec; uses rv32ie_pkg.
//
// Usage: each request on the s_ channel carries one instruction word. The block
// executes it against its program counter, register file and data memory and
// returns exactly one result on the m_ channel: next pc, the register write,
// the memory address of a load or store, a store flag and an unknown-opcode flag.
// Timing: the register file is read at the accept edge. For most instructions the
// result is registered on the m_ channel once the execute state finds the output
// register free. Loads need a further data memory read in the load state first.
// A new request is taken in the same cycle that the previous non-load result is
// registered, and the register write-back is forwarded to that read. Non-load
// instructions therefore sustain one per cycle while the output register is free.
// After a load the next request is taken only once the load result is registered.
// A result waiting in the output register does not block the next request; the
// block, loads and clearing apart, stalls only when a second result has no room.
// Reset: pc, registers and memory read as zero. After reset the data memory is
// cleared one 4-byte row per cycle (MEM_BYTES/4 rows, 1024 by default) and
// s_ready stays low until this finishes.
module rv32i_instruction_executor
    import rv32ie_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_instruction,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_next_pc,
    output logic        m_reg_written,
    output logic [4:0]  m_reg_index,
    output logic [31:0] m_reg_value,
    output logic        m_mem_written,
    output logic [31:0] m_mem_address,
    output logic        m_unknown_opcode
);

    state_t      state_reg, state_next;
    logic [31:0] instr_reg, pc_reg;
    logic [31:0] rs1_val, rs2_val, mem_rdata, ld_val;
    logic [4:0]  ld_rd_reg;
    logic [2:0]  ld_f3_reg;
    logic [31:0] ld_addr_reg;
    logic        ld_wr;
    logic        clr_busy, out_free, accept, exec_done, load_done;
    logic        rf_we;
    logic [4:0]  rf_wa;
    logic [31:0] rf_wd;
    exec_res_t   ex;

    logic        m_valid_reg;
    logic [31:0] m_next_pc_reg, m_reg_value_reg, m_mem_address_reg;
    logic [4:0]  m_reg_index_reg;
    logic        m_reg_written_reg, m_mem_written_reg, m_unknown_opcode_reg;

    rv32ie_regfile u_regfile (
        .aclk    (aclk),
        .aresetn (aresetn),
        .re      (accept),
        .ra1     (s_instruction[19:15]),
        .ra2     (s_instruction[24:20]),
        .we      (rf_we),
        .wa      (rf_wa),
        .wd      (rf_wd),
        .rd1     (rs1_val),
        .rd2     (rs2_val)
    );

    rv32ie_exec u_exec (
        .instr (instr_reg),
        .pc    (pc_reg),
        .a     (rs1_val),
        .b     (rs2_val),
        .res   (ex)
    );

    rv32ie_dmem u_dmem (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .re       (exec_done && ex.is_load),
        .raddr    (ex.addr),
        .we       (exec_done && ex.mw),
        .waddr    (ex.addr),
        .wsize    (instr_reg[13:12]),
        .wdata    (rs2_val),
        .rdata    (mem_rdata),
        .clr_busy (clr_busy)
    );

    assign out_free  = !m_valid_reg || m_ready;
    assign exec_done = (state_reg == ST_EXEC) && (ex.is_load || out_free);
    assign load_done = (state_reg == ST_LOAD) && out_free;
    assign s_ready   = (state_reg == ST_IDLE)
                    || ((state_reg == ST_EXEC) && !ex.is_load && out_free);
    assign accept    = s_valid && s_ready;

    always_comb begin
        unique case (ld_f3_reg)
            F3_BYTE:  ld_val = {{24{mem_rdata[7]}}, mem_rdata[7:0]};
            F3_HALF:  ld_val = {{16{mem_rdata[15]}}, mem_rdata[15:0]};
            F3_WORD:  ld_val = mem_rdata;
            F3_BYTEU: ld_val = {24'd0, mem_rdata[7:0]};
            F3_HALFU: ld_val = {16'd0, mem_rdata[15:0]};
            default:  ld_val = 32'd0;
        endcase
        ld_wr = (ld_rd_reg != 5'd0) && (ld_f3_reg != 3'd3) && (ld_f3_reg != 3'd6)
             && (ld_f3_reg != 3'd7);
    end

    always_comb begin
        if (state_reg == ST_LOAD) begin
            rf_we = load_done && ld_wr;
            rf_wa = ld_rd_reg;
            rf_wd = ld_val;
        end else begin
            rf_we = exec_done && !ex.is_load && ex.wr;
            rf_wa = instr_reg[11:7];
            rf_wd = ex.val;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: if (!clr_busy) state_next = ST_IDLE;
            ST_IDLE:  if (accept) state_next = ST_EXEC;
            ST_EXEC: begin
                if (exec_done) begin
                    if (ex.is_load) begin
                        state_next = ST_LOAD;
                    end else if (!accept) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_LOAD:  if (load_done) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg <= 32'd0;
        end else if (exec_done) begin
            pc_reg <= ex.next_pc;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            instr_reg <= s_instruction;
        end
        if (exec_done && ex.is_load) begin
            ld_rd_reg   <= instr_reg[11:7];
            ld_f3_reg   <= instr_reg[14:12];
            ld_addr_reg <= ex.addr;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if ((exec_done && !ex.is_load) || load_done) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_done) begin
            m_next_pc_reg        <= pc_reg;
            m_reg_written_reg    <= ld_wr;
            m_reg_index_reg      <= ld_wr ? ld_rd_reg : 5'd0;
            m_reg_value_reg      <= ld_wr ? ld_val : 32'd0;
            m_mem_written_reg    <= 1'b0;
            m_mem_address_reg    <= ld_addr_reg;
            m_unknown_opcode_reg <= 1'b0;
        end else if (exec_done && !ex.is_load) begin
            m_next_pc_reg        <= ex.next_pc;
            m_reg_written_reg    <= ex.wr;
            m_reg_index_reg      <= ex.wr ? instr_reg[11:7] : 5'd0;
            m_reg_value_reg      <= ex.val;
            m_mem_written_reg    <= ex.mw;
            m_mem_address_reg    <= ex.addr;
            m_unknown_opcode_reg <= ex.unk;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_next_pc        = m_next_pc_reg;
    assign m_reg_written    = m_reg_written_reg;
    assign m_reg_index      = m_reg_index_reg;
    assign m_reg_value      = m_reg_value_reg;
    assign m_mem_written    = m_mem_written_reg;
    assign m_mem_address    = m_mem_address_reg;
    assign m_unknown_opcode = m_unknown_opcode_reg;

endmodule

[design/rv32ie_regfile.sv]
// 32 x 32 register file in a two-read, one-write synchronous RAM.
// Valid bits give the reset value of zero; a same-cycle write is forwarded.
module rv32ie_regfile
    import rv32ie_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        re,
    input  logic [4:0]  ra1,
    input  logic [4:0]  ra2,
    input  logic        we,
    input  logic [4:0]  wa,
    input  logic [31:0] wd,
    output logic [31:0] rd1,
    output logic [31:0] rd2
);

    logic [31:0] rf_mem [32];
    logic [31:0] vld_reg;
    logic [31:0] raw1_reg, raw2_reg, fwdv_reg;
    logic        vld1_reg, vld2_reg, fwd1_reg, fwd2_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            rf_mem[wa] <= wd;
        end
        if (re) begin
            raw1_reg <= rf_mem[ra1];
            raw2_reg <= rf_mem[ra2];
            fwdv_reg <= wd;
            fwd1_reg <= we && (wa == ra1);
            fwd2_reg <= we && (wa == ra2);
            vld1_reg <= vld_reg[ra1];
            vld2_reg <= vld_reg[ra2];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (we) begin
            vld_reg[wa] <= 1'b1;
        end
    end

    assign rd1 = fwd1_reg ? fwdv_reg : (vld1_reg ? raw1_reg : 32'd0);
    assign rd2 = fwd2_reg ? fwdv_reg : (vld2_reg ? raw2_reg : 32'd0);

endmodule

[design/rv32ie_dmem.sv]
// Byte-addressed data memory as four byte-lane RAM banks with wrapping access.
// Runs a clearing pass after reset; uses rv32ie_pkg.
module rv32ie_dmem
    import rv32ie_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        re,
    input  logic [31:0] raddr,
    input  logic        we,
    input  logic [31:0] waddr,
    input  logic [1:0]  wsize,
    input  logic [31:0] wdata,
    output logic [31:0] rdata,
    output logic        clr_busy
);

    logic             clr_busy_reg;
    logic [ROW_W-1:0] clr_cnt_reg;
    logic [1:0]       off_reg;
    logic [7:0]       rbyte [4];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_busy_reg <= 1'b1;
            clr_cnt_reg  <= '0;
        end else if (clr_busy_reg) begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
            if (clr_cnt_reg == ROW_W'(MEM_ROWS - 1)) begin
                clr_busy_reg <= 1'b0;
            end
        end
    end

    assign clr_busy = clr_busy_reg;

    always_ff @(posedge aclk) begin
        if (re) begin
            off_reg <= raddr[1:0];
        end
    end

    for (genvar b = 0; b < 4; b++) begin : g_bank
        logic [7:0]       bank_mem [MEM_ROWS];
        logic [1:0]       rk, wk;
        logic [ROW_W+1:0] rsum, wsum;
        logic             wen;

        always_comb begin
            rk   = 2'(b) - raddr[1:0];
            wk   = 2'(b) - waddr[1:0];
            rsum = raddr[ROW_W+1:0] + (ROW_W+2)'(rk);
            wsum = waddr[ROW_W+1:0] + (ROW_W+2)'(wk);
            wen  = we && ((wk == 2'd0) || (wsize == 2'd1 && wk == 2'd1) || (wsize == 2'd2));
        end

        always_ff @(posedge aclk) begin
            if (clr_busy_reg) begin
                bank_mem[clr_cnt_reg] <= 8'd0;
            end else if (wen) begin
                bank_mem[wsum[ROW_W+1:2]] <= wdata[8*wk +: 8];
            end
            if (re) begin
                rbyte[b] <= bank_mem[rsum[ROW_W+1:2]];
            end
        end
    end

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            rdata[8*k +: 8] = rbyte[2'(off_reg + 2'(k))];
        end
    end

endmodule

[design/rv32ie_exec.sv]
// Decode and execute logic for one RV32I instruction word.
// Uses rv32ie_pkg for opcodes and the result struct; purely combinational.
module rv32ie_exec
    import rv32ie_pkg::*;
(
    input  logic [31:0] instr,
    input  logic [31:0] pc,
    input  logic [31:0] a,
    input  logic [31:0] b,
    output exec_res_t   res
);

    logic [2:0]  f3;
    logic [31:0] immi, imms, immb, immj, opb, alu_out, pc4;
    logic        alt, taken;

    always_comb begin
        f3   = instr[14:12];
        immi = {{20{instr[31]}}, instr[31:20]};
        imms = {{20{instr[31]}}, instr[31:25], instr[11:7]};
        immb = {{19{instr[31]}}, instr[31], instr[7], instr[30:25], instr[11:8], 1'b0};
        immj = {{11{instr[31]}}, instr[31], instr[19:12], instr[20], instr[30:21], 1'b0};
        pc4  = pc + 32'd4;
        opb  = (instr[6:0] == OP_REG) ? b : immi;
        alt  = instr[30] && ((f3 == 3'd5) || (f3 == 3'd0 && instr[6:0] == OP_REG));

        unique case (f3)
            3'd0:    alu_out = alt ? a - opb : a + opb;
            3'd1:    alu_out = a << opb[4:0];
            3'd2:    alu_out = {31'd0, $signed(a) < $signed(opb)};
            3'd3:    alu_out = {31'd0, a < opb};
            3'd4:    alu_out = a ^ opb;
            3'd5:    alu_out = alt ? 32'($signed(a) >>> opb[4:0]) : a >> opb[4:0];
            3'd6:    alu_out = a | opb;
            default: alu_out = a & opb;
        endcase

        unique case (f3)
            3'd0:    taken = (a == b);
            3'd1:    taken = (a != b);
            3'd4:    taken = $signed(a) < $signed(b);
            3'd5:    taken = !($signed(a) < $signed(b));
            3'd6:    taken = a < b;
            3'd7:    taken = a >= b;
            default: taken = 1'b0;
        endcase

        res = '{next_pc: pc4, wr: 1'b0, val: 32'd0, mw: 1'b0,
                addr: 32'd0, unk: 1'b0, is_load: 1'b0};

        unique case (instr[6:0])
            OP_LUI: begin
                res.wr  = 1'b1;
                res.val = instr & UPPER_MASK;
            end
            OP_AUIPC: begin
                res.wr  = 1'b1;
                res.val = pc + (instr & UPPER_MASK);
            end
            OP_JAL: begin
                res.wr      = 1'b1;
                res.val     = pc4;
                res.next_pc = pc + immj;
            end
            OP_JALR: begin
                res.wr      = 1'b1;
                res.val     = pc4;
                res.next_pc = (a + immi) & ~32'd1;
            end
            OP_BRANCH: begin
                if (taken) begin
                    res.next_pc = pc + immb;
                end
            end
            OP_LOAD: begin
                res.addr    = a + immi;
                res.is_load = 1'b1;
            end
            OP_STORE: begin
                res.addr = a + imms;
                res.mw   = (f3 == F3_BYTE) || (f3 == F3_HALF) || (f3 == F3_WORD);
            end
            OP_IMM, OP_REG: begin
                res.wr  = 1'b1;
                res.val = alu_out;
            end
            OP_FENCE, OP_SYSTEM: begin
            end
            default: begin
                res.unk     = 1'b1;
                res.next_pc = pc;
            end
        endcase

        if (instr[11:7] == 5'd0) begin
            res.wr = 1'b0;
        end
        if (!res.wr) begin
            res.val = 32'd0;
        end
    end

endmodule
